// File: rtl/core/srfc_pkg.sv
// shared types, constants and codes for the servo reply frame checker
`timescale 1ns / 1ps

package srfc_pkg;

    // frame layout
    localparam int unsigned HdrLen     = 7;
    localparam int unsigned MaxPayload = 248;

    localparam logic [7:0] SYNC_BYTE      = 8'hFF;
    localparam logic [7:0] CHK_MASK       = 8'hFE;
    localparam logic [7:0] CMD_REPLY_BIT  = 8'h40;
    localparam logic [7:0] HDR_LEN_B      = 8'(HdrLen);
    localparam logic [7:0] MAX_PAYLOAD_B  = 8'(MaxPayload);
    localparam logic [7:0] MAX_POSITION_B = 8'(HdrLen + MaxPayload - 1);

    // configuration register reset values
    localparam logic [7:0] RST_SERVO_ID   = 8'd1;
    localparam logic [7:0] RST_EXP_CMD    = 8'd7;
    localparam logic [7:0] RST_PAY_LEN    = 8'd10;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SERVO_ID        = 3'd0,
        CFG_EXPECTED_CMD    = 3'd1,
        CFG_PAYLOAD_LENGTH  = 3'd2,
        CFG_ECHO_CHECK      = 3'd3,
        CFG_READ_START_ADDR = 3'd4,
        CFG_READ_LENGTH     = 3'd5
    } t_cfg_index;

    // input actions
    typedef enum logic {
        ACT_RX_BYTE = 1'b0,
        ACT_TIMEOUT = 1'b1
    } t_action;

    // frame status codes
    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_HDR_TIMEOUT  = 4'd1,
        ST_SYNC1        = 4'd2,
        ST_SYNC2        = 4'd3,
        ST_ID           = 4'd4,
        ST_CMD          = 4'd5,
        ST_SIZE         = 4'd6,
        ST_DATA_TIMEOUT = 4'd7,
        ST_CHK1         = 4'd8,
        ST_CHK2         = 4'd9,
        ST_OFFSET       = 4'd10,
        ST_LENGTH       = 4'd11
    } t_status;

    // input item
    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_item;

    // result item
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       done_res;
        logic [3:0] status_code;
    } t_out_item;

endpackage

// File: rtl/core/servo_reply_frame_checker.sv
// servo reply frame checker: header check, payload pass-through, checksum and echo check
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_item (action, rx_byte)
//  out     | output    | o_out_valid/ i_out_ready| o_out_item (data, done, status)
//  cfg     | input     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
//  one item per cycle unless the result register stalls; each item is resolved in the
//  cycle it is accepted and any result appears from the result register on the next cycle
//  a stalled result register holds o_in_ready low unless i_out_ready frees it that cycle
//  synchronous active-low reset clears the frame position, checksum and echo flags and
//  loads the register defaults; the header store needs no reset
`timescale 1ns / 1ps

module servo_reply_frame_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  srfc_pkg::t_in_item   i_in_item,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output srfc_pkg::t_out_item  o_out_item,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    // configuration registers
    logic [7:0] r_servo_id;
    logic [7:0] r_exp_cmd;
    logic [7:0] r_pay_len;
    logic       r_echo_chk;
    logic [7:0] r_rd_addr;
    logic [7:0] r_rd_len;

    // frame state
    logic [7:0] r_pos;
    logic [7:0] r_hdr [srfc_pkg::HdrLen];
    logic [7:0] r_xor;
    logic       r_off_mis;
    logic       r_len_mis;

    logic [7:0] n_pos;
    logic [7:0] n_xor;
    logic       n_off_mis;
    logic       n_len_mis;

    // result register
    logic                r_out_valid;
    srfc_pkg::t_out_item r_out_item;
    logic                n_emit;
    srfc_pkg::t_out_item n_item;

    // decode helpers
    logic       in_acc;
    logic [7:0] rx;
    logic [7:0] eff_len;
    logic [7:0] exp_size;
    logic [7:0] exp_cmd;
    logic       in_hdr;
    logic       hdr_last;
    logic [7:0] idx;
    logic [7:0] pay_xor;
    logic       pay_last;
    logic [7:0] hdr_xor;
    srfc_pkg::t_status hdr_code;

    // frame-end status from checksum and echo flags
    function automatic srfc_pkg::t_status finish_status(
        input logic [7:0] x,
        input logic [7:0] chk1,
        input logic [7:0] chk2,
        input logic       echo,
        input logic       off_mis,
        input logic       len_mis
    );
        srfc_pkg::t_status st;
        st = srfc_pkg::ST_OK;
        if (chk1 != (x & srfc_pkg::CHK_MASK)) begin
            st = srfc_pkg::ST_CHK1;
        end else if (chk2 != (~x & srfc_pkg::CHK_MASK)) begin
            st = srfc_pkg::ST_CHK2;
        end else if (echo && off_mis) begin
            st = srfc_pkg::ST_OFFSET;
        end else if (echo && len_mis) begin
            st = srfc_pkg::ST_LENGTH;
        end
        return st;
    endfunction

    // handshakes
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // shared decode
    assign rx       = i_in_item.rx_byte;
    assign eff_len  = (r_pay_len > srfc_pkg::MAX_PAYLOAD_B) ? srfc_pkg::MAX_PAYLOAD_B
                                                            : r_pay_len;
    assign exp_size = eff_len + srfc_pkg::HDR_LEN_B;
    assign exp_cmd  = r_exp_cmd | srfc_pkg::CMD_REPLY_BIT;
    assign in_hdr   = r_pos < srfc_pkg::HDR_LEN_B;
    assign hdr_last = r_pos == (srfc_pkg::HDR_LEN_B - 8'd1);
    assign idx      = r_pos - srfc_pkg::HDR_LEN_B;
    assign pay_xor  = r_xor ^ rx;
    assign pay_last = (idx + 8'd1) >= eff_len;
    assign hdr_xor  = exp_size ^ r_servo_id ^ exp_cmd;

    // header fault priority on the seventh byte
    always_comb begin
        hdr_code = srfc_pkg::ST_OK;
        if (r_hdr[0] != srfc_pkg::SYNC_BYTE) begin
            hdr_code = srfc_pkg::ST_SYNC1;
        end else if (r_hdr[1] != srfc_pkg::SYNC_BYTE) begin
            hdr_code = srfc_pkg::ST_SYNC2;
        end else if (r_hdr[3] != r_servo_id) begin
            hdr_code = srfc_pkg::ST_ID;
        end else if (r_hdr[4] != exp_cmd) begin
            hdr_code = srfc_pkg::ST_CMD;
        end else if (r_hdr[2] != exp_size) begin
            hdr_code = srfc_pkg::ST_SIZE;
        end
    end

    // next frame state and result for the current item
    always_comb begin
        n_pos     = r_pos;
        n_xor     = r_xor;
        n_off_mis = r_off_mis;
        n_len_mis = r_len_mis;
        n_emit    = 1'b0;
        n_item    = '0;
        if (i_in_item.action == srfc_pkg::ACT_TIMEOUT) begin
            n_pos              = '0;
            n_emit             = 1'b1;
            n_item.done_res    = 1'b1;
            n_item.status_code = in_hdr ? srfc_pkg::ST_HDR_TIMEOUT
                                        : srfc_pkg::ST_DATA_TIMEOUT;
        end else if (in_hdr) begin
            n_pos = r_pos + 8'd1;
            if (hdr_last) begin
                if (hdr_code != srfc_pkg::ST_OK) begin
                    n_pos              = '0;
                    n_emit             = 1'b1;
                    n_item.done_res    = 1'b1;
                    n_item.status_code = hdr_code;
                end else begin
                    n_xor     = hdr_xor;
                    n_off_mis = 1'b0;
                    n_len_mis = 1'b0;
                    // empty payload: check bytes resolve with the header
                    if (eff_len == 8'd0) begin
                        n_pos              = '0;
                        n_emit             = 1'b1;
                        n_item.done_res    = 1'b1;
                        n_item.status_code = finish_status(hdr_xor, r_hdr[5], rx,
                                                           r_echo_chk, 1'b0, 1'b0);
                    end
                end
            end
        end else begin
            n_xor = pay_xor;
            if (idx == 8'd2) begin
                n_off_mis = rx != r_rd_addr;
            end
            if (idx == 8'd3) begin
                n_len_mis = rx != r_rd_len;
            end
            n_emit            = 1'b1;
            n_item.data_valid = 1'b1;
            n_item.data_byte  = rx;
            if (pay_last) begin
                n_pos              = '0;
                n_item.done_res    = 1'b1;
                n_item.status_code = finish_status(pay_xor, r_hdr[5], r_hdr[6],
                                                   r_echo_chk, n_off_mis, n_len_mis);
            end else begin
                n_pos = r_pos + 8'd1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servo_id <= srfc_pkg::RST_SERVO_ID;
            r_exp_cmd  <= srfc_pkg::RST_EXP_CMD;
            r_pay_len  <= srfc_pkg::RST_PAY_LEN;
            r_echo_chk <= 1'b0;
            r_rd_addr  <= '0;
            r_rd_len   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (srfc_pkg::t_cfg_index'(i_cfg_index))
                srfc_pkg::CFG_SERVO_ID:        r_servo_id <= i_cfg_data;
                srfc_pkg::CFG_EXPECTED_CMD:    r_exp_cmd  <= i_cfg_data;
                srfc_pkg::CFG_PAYLOAD_LENGTH:  r_pay_len  <= i_cfg_data;
                srfc_pkg::CFG_ECHO_CHECK:      r_echo_chk <= i_cfg_data[0];
                srfc_pkg::CFG_READ_START_ADDR: r_rd_addr  <= i_cfg_data;
                srfc_pkg::CFG_READ_LENGTH:     r_rd_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // header store, written at the current position
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_item.action == srfc_pkg::ACT_RX_BYTE && in_hdr) begin
            r_hdr[r_pos[2:0]] <= rx;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_xor     <= '0;
            r_off_mis <= 1'b0;
            r_len_mis <= 1'b0;
        end else if (in_acc) begin
            r_pos     <= n_pos;
            r_xor     <= n_xor;
            r_off_mis <= n_off_mis;
            r_len_mis <= n_len_mis;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit) begin
            r_out_item <= n_item;
        end
    end

`ifndef ASSERT_OFF
    // a result that does not end a frame carries a payload byte
    a_partial_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_item.done_res |-> r_out_item.data_valid)
        else $error("result without done or data");

    // idle fields read as zero
    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.data_valid || r_out_item.data_byte == 8'd0) &&
                        (r_out_item.done_res || r_out_item.status_code == 4'd0))
        else $error("unused result field not zero");

    // a finished frame restarts at the first header byte
    a_restart_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && n_emit && n_item.done_res |=> r_pos == 8'd0)
        else $error("position not cleared at frame end");

    // position stays within the longest frame
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= srfc_pkg::MAX_POSITION_B)
        else $error("frame position out of range");
`endif

endmodule

// File: tb/servo_reply_monitor.sv
// channel monitor for the servo reply frame checker: predicts each result and compares
`timescale 1ns / 1ps

module servo_reply_monitor
    import srfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input items
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_item,
    // result items
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_item,
    // configuration writes
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // to the top
    output int         o_fail_count,
    output int         o_outstanding
);

    // register copies
    logic [7:0] id_reg;
    logic [7:0] cmd_reg;
    logic [7:0] len_reg;
    logic       echo_reg;
    logic [7:0] addr_reg;
    logic [7:0] rlen_reg;

    // frame state
    int unsigned frame_pos;
    logic [7:0]  hdr_bytes [HdrLen];
    logic [7:0]  xor_acc;
    logic        offset_bad;
    logic        length_bad;

    t_out_item   expected_results [$];
    int          mismatches = 0;

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    // checksum and echo checks at the end of a frame
    function automatic t_status close_frame();
        frame_pos = 0;
        if (hdr_bytes[5] != (xor_acc & CHK_MASK)) return ST_CHK1;
        if (hdr_bytes[6] != (~xor_acc & CHK_MASK)) return ST_CHK2;
        if (echo_reg) begin
            if (offset_bad) return ST_OFFSET;
            if (length_bad) return ST_LENGTH;
        end
        return ST_OK;
    endfunction

    // advances the frame by one item and works out the result it causes, if any
    task automatic advance_frame(input t_in_item it, output bit emits, output t_out_item res);
        logic [7:0]  plen;
        logic [7:0]  size_b;
        logic [7:0]  cmd_b;
        int unsigned pidx;
        t_status     code;
        emits  = 1'b0;
        res    = '0;
        plen   = (len_reg > MAX_PAYLOAD_B) ? MAX_PAYLOAD_B : len_reg;
        size_b = plen + HDR_LEN_B;
        cmd_b  = cmd_reg | CMD_REPLY_BIT;
        if (it.action == ACT_TIMEOUT) begin
            res.done_res    = 1'b1;
            res.status_code = (frame_pos < HdrLen) ? ST_HDR_TIMEOUT : ST_DATA_TIMEOUT;
            frame_pos       = 0;
            emits           = 1'b1;
        end else if (frame_pos < HdrLen) begin
            hdr_bytes[frame_pos] = it.rx_byte;
            frame_pos++;
            if (frame_pos == HdrLen) begin
                // first header fault wins
                code = ST_OK;
                if (hdr_bytes[0] != SYNC_BYTE) code = ST_SYNC1;
                else if (hdr_bytes[1] != SYNC_BYTE) code = ST_SYNC2;
                else if (hdr_bytes[3] != id_reg) code = ST_ID;
                else if (hdr_bytes[4] != cmd_b) code = ST_CMD;
                else if (hdr_bytes[2] != size_b) code = ST_SIZE;
                if (code != ST_OK) begin
                    frame_pos       = 0;
                    emits           = 1'b1;
                    res.done_res    = 1'b1;
                    res.status_code = code;
                end else begin
                    xor_acc    = size_b ^ id_reg ^ cmd_b;
                    offset_bad = 1'b0;
                    length_bad = 1'b0;
                    // empty payload ends the frame right here
                    if (plen == 0) begin
                        emits           = 1'b1;
                        res.done_res    = 1'b1;
                        res.status_code = close_frame();
                    end
                end
            end
        end else begin
            // payload byte
            pidx    = frame_pos - HdrLen;
            xor_acc = xor_acc ^ it.rx_byte;
            if (pidx == 2) offset_bad = (it.rx_byte != addr_reg);
            if (pidx == 3) length_bad = (it.rx_byte != rlen_reg);
            emits          = 1'b1;
            res.data_valid = 1'b1;
            res.data_byte  = it.rx_byte;
            if (pidx + 1 >= plen) begin
                res.done_res    = 1'b1;
                res.status_code = close_frame();
            end else begin
                frame_pos++;
            end
        end
    endtask

    // watch all three channels at each rising edge
    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item res;
        bit        emits;
        if (!i_rst_n) begin
            id_reg     = RST_SERVO_ID;
            cmd_reg    = RST_EXP_CMD;
            len_reg    = RST_PAY_LEN;
            echo_reg   = 1'b0;
            addr_reg   = 8'h00;
            rlen_reg   = 8'h00;
            frame_pos  = 0;
            xor_acc    = 8'h00;
            offset_bad = 1'b0;
            length_bad = 1'b0;
            expected_results.delete();
        end else begin
            // compare a result with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, data_byte", i_out_item.data_byte,
                                    8'h00);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.data_valid !== want.data_valid)
                        report_mismatch("data_valid", 8'(i_out_item.data_valid),
                                        8'(want.data_valid));
                    if (i_out_item.data_byte !== want.data_byte)
                        report_mismatch("data_byte", i_out_item.data_byte, want.data_byte);
                    if (i_out_item.done_res !== want.done_res)
                        report_mismatch("done_res", 8'(i_out_item.done_res),
                                        8'(want.done_res));
                    if (i_out_item.status_code !== want.status_code)
                        report_mismatch("status_code", 8'(i_out_item.status_code),
                                        8'(want.status_code));
                end
            end
            // predict from an accepted item, with the registers as they were before this edge
            if (i_in_valid && i_in_ready) begin
                advance_frame(i_in_item, emits, res);
                if (emits) expected_results.push_back(res);
            end
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SERVO_ID:        id_reg   = i_cfg_data;
                    CFG_EXPECTED_CMD:    cmd_reg  = i_cfg_data;
                    CFG_PAYLOAD_LENGTH:  len_reg  = i_cfg_data;
                    CFG_ECHO_CHECK:      echo_reg = i_cfg_data[0];
                    CFG_READ_START_ADDR: addr_reg = i_cfg_data;
                    CFG_READ_LENGTH:     rlen_reg = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_outstanding <= expected_results.size();
        o_fail_count  <= mismatches;
    end

endmodule

// File: tb/tb_top.sv
// top of the servo reply frame checker testbench: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module tb_top;
    import srfc_pkg::*;

    localparam int StallLimit  = 2000;
    localparam int RandomItems = 900;
    localparam int HoldCycles  = 80;

    // how a generated frame is spoiled
    typedef enum int {
        FLT_NONE,
        FLT_SYNC1,
        FLT_SYNC2,
        FLT_SIZE,
        FLT_ID,
        FLT_CMD,
        FLT_CHK1,
        FLT_CHK2,
        FLT_OFFSET,
        FLT_LENGTH,
        FLT_HDR_TIMEOUT,
        FLT_DATA_TIMEOUT,
        FLT_NOISE
    } t_frame_fault;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_ready;
    t_out_item  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    int fail_count;
    int outstanding;
    int send_idle_pct = 11;
    int recv_idle_pct = 78;
    int hold_left     = 0;
    int items_sent    = 0;

    // register values as last written, used to build frames
    logic [7:0] cur_id   = RST_SERVO_ID;
    logic [7:0] cur_cmd  = RST_EXP_CMD;
    logic [7:0] cur_len  = RST_PAY_LEN;
    logic       cur_echo = 1'b0;
    logic [7:0] cur_addr = 8'h00;
    logic [7:0] cur_rlen = 8'h00;

    servo_reply_frame_checker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    servo_reply_monitor u_reply_monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial begin : watchdog
        int stall;
        stall = 0;
        wait (rst_n === 1'b1);
        while (stall < StallLimit) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("watchdog: no handshake for %0d cycles", StallLimit);
        $display("Some tests failed");
        $finish;
    end

    // offers one item, with a random gap first; valid stays high afterwards
    task automatic send_item(input logic act, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{action: act, rx_byte: b};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // stop offering and let every expected result drain
    task automatic drain_block();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // one register write; cfg_valid is left high for a following write
    task automatic write_reg(input t_cfg_index idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        case (idx)
            CFG_SERVO_ID:        cur_id   = val;
            CFG_EXPECTED_CMD:    cur_cmd  = val;
            CFG_PAYLOAD_LENGTH:  cur_len  = val;
            CFG_ECHO_CHECK:      cur_echo = val[0];
            CFG_READ_START_ADDR: cur_addr = val;
            CFG_READ_LENGTH:     cur_rlen = val;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] id, input logic [7:0] cmd,
                                input logic [7:0] len, input logic [7:0] echo,
                                input logic [7:0] addr, input logic [7:0] rlen);
        write_reg(CFG_SERVO_ID, id);
        write_reg(CFG_EXPECTED_CMD, cmd);
        write_reg(CFG_PAYLOAD_LENGTH, len);
        write_reg(CFG_ECHO_CHECK, echo);
        write_reg(CFG_READ_START_ADDR, addr);
        write_reg(CFG_READ_LENGTH, rlen);
        cfg_valid <= 1'b0;
    endtask

    // byte values weighted toward the extremes
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly short payloads, now and then the longest and oversized ones
    function automatic logic [7:0] pick_len();
        case ($urandom_range(0, 19))
            0:       return MAX_PAYLOAD_B;
            1:       return 8'($urandom_range(249, 255));
            2:       return 8'($urandom_range(13, 60));
            default: return 8'($urandom_range(0, 12));
        endcase
    endfunction

    function automatic t_frame_fault pick_fault();
        if ($urandom_range(0, 99) < 55) return FLT_NONE;
        return t_frame_fault'($urandom_range(1, int'(FLT_NOISE)));
    endfunction

    // builds a reply frame for the current registers and sends it, spoiled as asked;
    // with retune the servo id is rewritten after the third header byte
    task automatic send_frame(input t_frame_fault fault, input bit retune,
                              input logic [7:0] late_id);
        logic [7:0] bytes [$];
        logic [7:0] payload [$];
        logic [7:0] plen;
        logic [7:0] size_b;
        logic [7:0] cmd_b;
        logic [7:0] id_b;
        logic [7:0] sum;
        logic [7:0] p;
        logic [7:0] flip;
        int         cut;
        // noise: random bytes and timeouts, then a timeout to restart the frame
        if (fault == FLT_NOISE) begin
            repeat ($urandom_range(1, 12)) begin
                if ($urandom_range(0, 9) == 0) send_item(ACT_TIMEOUT, 8'($urandom));
                else send_item(ACT_RX_BYTE, pick_byte());
            end
            send_item(ACT_TIMEOUT, 8'($urandom));
            return;
        end
        plen   = (cur_len > MAX_PAYLOAD_B) ? MAX_PAYLOAD_B : cur_len;
        size_b = plen + HDR_LEN_B;
        cmd_b  = cur_cmd | CMD_REPLY_BIT;
        id_b   = retune ? late_id : cur_id;
        sum    = size_b ^ id_b ^ cmd_b;
        flip   = 8'($urandom_range(1, 255));
        // payload, with the echo bytes mostly matching the read registers
        for (int i = 0; i < plen; i++) begin
            p = 8'($urandom);
            if (cur_echo || $urandom_range(0, 1) == 0) begin
                if (i == 2) p = cur_addr;
                if (i == 3) p = cur_rlen;
            end
            if (i == 2 && fault == FLT_OFFSET) p = p ^ flip;
            if (i == 3 && fault == FLT_LENGTH) p = p ^ flip;
            sum = sum ^ p;
            payload.push_back(p);
        end
        // header
        bytes.push_back(SYNC_BYTE);
        bytes.push_back(SYNC_BYTE);
        bytes.push_back(size_b);
        bytes.push_back(id_b);
        bytes.push_back(cmd_b);
        bytes.push_back(sum & CHK_MASK);
        bytes.push_back(~sum & CHK_MASK);
        case (fault)
            FLT_SYNC1: bytes[0] = bytes[0] ^ flip;
            FLT_SYNC2: bytes[1] = bytes[1] ^ flip;
            FLT_SIZE:  bytes[2] = bytes[2] ^ flip;
            FLT_ID:    bytes[3] = bytes[3] ^ flip;
            FLT_CMD:   bytes[4] = bytes[4] ^ flip;
            FLT_CHK1:  bytes[5] = bytes[5] ^ flip;
            FLT_CHK2:  bytes[6] = bytes[6] ^ flip;
            default: ;
        endcase
        foreach (payload[i]) bytes.push_back(payload[i]);
        // where a timeout cuts the frame short
        cut = bytes.size();
        if (fault == FLT_HDR_TIMEOUT) cut = $urandom_range(0, HdrLen - 1);
        if (fault == FLT_DATA_TIMEOUT && plen > 0) cut = HdrLen + $urandom_range(0, plen - 1);
        for (int i = 0; i < cut; i++) begin
            if (retune && i == 3) begin
                drain_block();
                write_reg(CFG_SERVO_ID, late_id);
                cfg_valid <= 1'b0;
            end
            send_item(ACT_RX_BYTE, bytes[i]);
        end
        if (fault == FLT_HDR_TIMEOUT || fault == FLT_DATA_TIMEOUT)
            send_item(ACT_TIMEOUT, 8'($urandom));
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int base;
        int done_items;
        int next_hold;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // timeout with no frame under way
        send_item(ACT_TIMEOUT, 8'hFF);
        drain_block();
        // extreme id and command, empty payload with echo check on
        program_regs(8'hFF, 8'hBF, 8'h00, 8'h01, 8'h00, 8'hFF);
        send_frame(FLT_NONE, 1'b0, 8'h00);
        drain_block();
        // four payload bytes with echo, id changed in the middle of the header
        write_reg(CFG_PAYLOAD_LENGTH, 8'd4);
        cfg_valid <= 1'b0;
        send_frame(FLT_NONE, 1'b1, 8'h00);
        // timeout part way through a header
        send_item(ACT_RX_BYTE, 8'hFF);
        send_item(ACT_RX_BYTE, 8'h00);
        send_item(ACT_TIMEOUT, 8'h00);

        // random frames under changing settings and idling modes
        base      = items_sent;
        next_hold = 150;
        while (items_sent - base < RandomItems) begin
            done_items = items_sent - base;
            if (done_items < 300) begin
                send_idle_pct = 11;
                recv_idle_pct = 78;
            end else if (done_items < 600) begin
                send_idle_pct = 78;
                recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain_block();
            program_regs(pick_byte(), pick_byte(), pick_len(),
                         {7'($urandom), 1'($urandom)}, pick_byte(), pick_byte());
            repeat ((cur_len > 12) ? 1 : $urandom_range(2, 6)) begin
                // long receiver hold-off while items keep coming
                if (items_sent - base >= next_hold) begin
                    hold_left = HoldCycles;
                    next_hold += 550;
                end
                send_frame(pick_fault(), 1'b0, 8'h00);
            end
        end

        drain_block();
        repeat (5) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/srfc_pkg.sv
rtl/core/servo_reply_frame_checker.sv
tb/servo_reply_monitor.sv
tb/tb_top.sv
